// ===== src/rxagc_pkg.sv =====
// shared types, constants and gain tables for the rx agc gain stepper
`timescale 1ns / 1ps
`default_nettype none

package rxagc_pkg;

   localparam int RSSI_W  = 18;
   localparam int LNA_W   = 4;
   localparam int PGA_W   = 5;
   localparam int DB_W    = 18;
   localparam int IDX_W   = 6;
   localparam int MANT_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int EXP_W   = 5;

   localparam logic [RSSI_W-1:0] WANTED_RESET  = 18'd28672;
   localparam logic [RSSI_W-1:0] COARSE_LIMIT  = 18'h14000;
   localparam logic [LNA_W-1:0]  LNA_RESET     = 4'd11;
   localparam logic [PGA_W-1:0]  PGA_RESET     = 5'd31;
   localparam logic [LNA_W-1:0]  LNA_BACKOFF   = 4'd3;
   localparam logic [PGA_W-1:0]  PGA_BACKOFF   = 5'd12;
   localparam logic [IDX_W-1:0]  TABLE_LAST    = 6'd61;
   localparam logic [MANT_W-1:0] DB_PER_OCTAVE = 32'd394566;

   localparam logic [LNA_W-1:0] LNA_TAB [0:61] = '{
      4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3,
      4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6,
      4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8,
      4'd9, 4'd9, 4'd9, 4'd9, 4'd10, 4'd10, 4'd10, 4'd10,
      4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
      4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
      4'd12, 4'd13, 4'd14, 4'd15
   };

   localparam logic [PGA_W-1:0] PGA_TAB [0:61] = '{
      5'd0, 5'd1, 5'd2, 5'd0, 5'd1, 5'd2, 5'd3, 5'd1, 5'd2, 5'd3, 5'd4,
      5'd2, 5'd3, 5'd4, 5'd5, 5'd3, 5'd4, 5'd5, 5'd6, 5'd4, 5'd5,
      5'd6, 5'd7, 5'd5, 5'd6, 5'd7, 5'd8, 5'd6, 5'd7, 5'd8, 5'd9,
      5'd7, 5'd8, 5'd9, 5'd10, 5'd10, 5'd11, 5'd12, 5'd13,
      5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
      5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31,
      5'd31, 5'd31, 5'd31, 5'd31
   };

   typedef struct packed {
      logic [LNA_W-1:0] lna;
      logic [PGA_W-1:0] pga;
      logic             changed;
   } gain_upd_type;

   // leading-one position of a non-zero sample
   function automatic logic [EXP_W-1:0] msb_pos(input logic [RSSI_W-1:0] x);
      logic [EXP_W-1:0] n;
      n = '0;
      for (int i = 0; i < RSSI_W; i++) begin
         if (x[i]) begin
            n = EXP_W'(i);
         end
      end
      return n;
   endfunction

   // mantissa in q1.31 with the leading one at bit 31
   function automatic logic [MANT_W-1:0] norm_mant(input logic [RSSI_W-1:0] x,
                                                   input logic [EXP_W-1:0] n);
      logic [MANT_W-1:0] wide;
      wide = {{(MANT_W-RSSI_W){1'b0}}, x};
      return wide << (EXP_W'(MANT_W-1) - n);
   endfunction

endpackage

`default_nettype wire

// ===== src/rxagc_mult.sv =====
// registered 32x32 unsigned multiplier shared by the log and scaling steps
`timescale 1ns / 1ps
`default_nettype none

module rxagc_mult (
   input  wire logic                            clock,
   input  wire logic [rxagc_pkg::MANT_W-1:0]    op_a,
   input  wire logic [rxagc_pkg::MANT_W-1:0]    op_b,
   output logic      [2*rxagc_pkg::MANT_W-1:0]  prod
);

   logic [2*rxagc_pkg::MANT_W-1:0] prod_ff;
   logic [2*rxagc_pkg::MANT_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== src/rxagc_log_db.sv =====
// iterative level error: log2 by repeated squaring, then scale to db in q8.8
`timescale 1ns / 1ps
`default_nettype none

module rxagc_log_db (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [rxagc_pkg::RSSI_W-1:0]      wanted,
   input  wire logic [rxagc_pkg::RSSI_W-1:0]      sample,
   output logic                                   done,
   output logic signed [rxagc_pkg::DB_W-1:0]      db
);

   localparam int LOG_W = rxagc_pkg::EXP_W + rxagc_pkg::FRAC_W;
   localparam int PW    = 2 * rxagc_pkg::MANT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_W,
      ST_SQ_R,
      ST_DIFF,
      ST_PROD,
      ST_FIN
   } state_type;

   state_type state_ff;
   logic [3:0]                       cnt_ff;
   logic [rxagc_pkg::FRAC_W-1:0]     frac_ff;
   logic [LOG_W-1:0]                 log_w_ff;
   logic [rxagc_pkg::EXP_W-1:0]      exp_w_ff;
   logic [rxagc_pkg::EXP_W-1:0]      exp_r_ff;
   logic [rxagc_pkg::RSSI_W-1:0]     sample_ff;
   logic [LOG_W-1:0]                 mag_ff;
   logic                             neg_ff;
   logic                             done_ff;
   logic signed [rxagc_pkg::DB_W-1:0] db_ff;

   logic [rxagc_pkg::MANT_W-1:0]     op_a;
   logic [rxagc_pkg::MANT_W-1:0]     op_b;
   logic [PW-1:0]                    prod;
   logic                             sq_bit;
   logic [rxagc_pkg::MANT_W-1:0]     m_next;
   logic [rxagc_pkg::FRAC_W-1:0]     frac_in;
   logic [rxagc_pkg::EXP_W-1:0]      exp_w;
   logic [rxagc_pkg::EXP_W-1:0]      exp_r;
   logic [rxagc_pkg::MANT_W-1:0]     mant_w;
   logic [rxagc_pkg::MANT_W-1:0]     mant_r;
   logic signed [LOG_W:0]            diff;
   logic [LOG_W:0]                   diff_abs;
   logic [40:0]                      up_sum;
   logic [16:0]                      db_mag;
   logic signed [rxagc_pkg::DB_W-1:0] db_in;

   rxagc_mult u_mult (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign exp_w  = rxagc_pkg::msb_pos(wanted);
   assign exp_r  = rxagc_pkg::msb_pos(sample_ff);
   assign mant_w = rxagc_pkg::norm_mant(wanted, exp_w);
   assign mant_r = rxagc_pkg::norm_mant(sample_ff, exp_r);

   // square is q2.62; one fraction bit per step, renormalize to q1.31
   assign sq_bit  = prod[PW-1];
   assign m_next  = sq_bit ? prod[PW-1:rxagc_pkg::MANT_W] : prod[PW-2:rxagc_pkg::MANT_W-1];
   assign frac_in = {frac_ff[rxagc_pkg::FRAC_W-2:0], sq_bit};

   assign diff     = $signed({1'b0, log_w_ff}) - $signed({1'b0, exp_r_ff, frac_ff});
   assign diff_abs = diff[LOG_W] ? (LOG_W+1)'(-diff) : diff;

   // negative product rounds toward minus infinity
   assign up_sum = {1'b0, prod[39:0]} + 41'hFF_FFFF;
   assign db_mag = up_sum[40:24];
   assign db_in  = neg_ff ? -$signed({1'b0, db_mag})
                          : $signed({2'b0, prod[39:24]});

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_IDLE: begin
            op_a = mant_w;
            op_b = mant_w;
         end
         ST_SQ_W: begin
            if (cnt_ff == 4'hF) begin
               op_a = mant_r;
               op_b = mant_r;
            end else begin
               op_a = m_next;
               op_b = m_next;
            end
         end
         ST_SQ_R: begin
            op_a = m_next;
            op_b = m_next;
         end
         ST_PROD: begin
            op_a = {{(rxagc_pkg::MANT_W-LOG_W){1'b0}}, mag_ff};
            op_b = rxagc_pkg::DB_PER_OCTAVE;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  exp_w_ff  <= exp_w;
                  sample_ff <= sample;
                  cnt_ff    <= '0;
                  state_ff  <= ST_SQ_W;
               end
            end
            ST_SQ_W: begin
               frac_ff <= frac_in;
               cnt_ff  <= cnt_ff + 4'd1;
               if (cnt_ff == 4'hF) begin
                  log_w_ff <= {exp_w_ff, frac_in};
                  exp_r_ff <= exp_r;
                  state_ff <= ST_SQ_R;
               end
            end
            ST_SQ_R: begin
               frac_ff <= frac_in;
               cnt_ff  <= cnt_ff + 4'd1;
               if (cnt_ff == 4'hF) begin
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               neg_ff   <= diff[LOG_W];
               mag_ff   <= diff_abs[LOG_W-1:0];
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               db_ff    <= db_in;
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign db   = db_ff;

endmodule

`default_nettype wire

// ===== src/rxagc_gain_sel.sv =====
// gain decision: coarse back-off or table step from current gains and level error
`timescale 1ns / 1ps
`default_nettype none

module rxagc_gain_sel (
   input  wire logic [rxagc_pkg::LNA_W-1:0]        lna,
   input  wire logic [rxagc_pkg::PGA_W-1:0]        pga,
   input  wire logic [rxagc_pkg::RSSI_W-1:0]       sample,
   input  wire logic signed [rxagc_pkg::DB_W-1:0]  db,
   output rxagc_pkg::gain_upd_type                 upd
);

   logic [5:0]                    avail;
   logic signed [7:0]             total;
   logic signed [19:0]            sum;
   logic [rxagc_pkg::IDX_W-1:0]   idx;
   logic                          db_neg;
   logic                          db_pos;
   logic                          coarse;
   logic                          step;
   logic [rxagc_pkg::LNA_W-1:0]   tab_lna;
   logic [rxagc_pkg::PGA_W-1:0]   tab_pga;

   assign avail = (lna <= 4'd9) ? 6'(3 * (4'd11 - lna)) : {2'b0, 4'd15 - lna};
   assign total = 8'sd30 - $signed({2'b0, avail}) + $signed({3'b0, pga});
   assign sum   = $signed({{4{total[7]}}, total, 8'b0}) + 20'(db);

   always_comb begin
      if (sum[19]) begin
         idx = '0;
      end else if (sum[19:8] > 12'(rxagc_pkg::TABLE_LAST)) begin
         idx = rxagc_pkg::TABLE_LAST;
      end else begin
         idx = sum[13:8];
      end
   end

   assign tab_lna = rxagc_pkg::LNA_TAB[idx];
   assign tab_pga = rxagc_pkg::PGA_TAB[idx];

   assign db_neg = db[rxagc_pkg::DB_W-1];
   assign db_pos = !db_neg && (db != '0);
   assign coarse = db_neg && (sample > rxagc_pkg::COARSE_LIMIT);
   assign step   = db_neg || (db_pos && !(avail == '0 && pga == rxagc_pkg::PGA_RESET));

   always_comb begin
      upd.lna     = lna;
      upd.pga     = pga;
      upd.changed = 1'b0;
      if (coarse) begin
         upd.lna     = (lna < rxagc_pkg::LNA_BACKOFF) ? '0 : lna - rxagc_pkg::LNA_BACKOFF;
         upd.pga     = (pga < rxagc_pkg::PGA_BACKOFF) ? '0 : pga - rxagc_pkg::PGA_BACKOFF;
         upd.changed = 1'b1;
      end else if (step && (tab_lna != lna || tab_pga != pga)) begin
         upd.lna     = tab_lna;
         upd.pga     = tab_pga;
         upd.changed = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== src/rx_agc_gain_stepper_core.sv =====
// top level of the rx agc gain stepper: handshakes, gain state and result register
//
//  port group  | dir | handshake            | payload
//  req_        | in  | req_valid/req_stall  | rssi_sample
//  rsp_        | out | rsp_valid/rsp_stall  | lna_gain, pga_gain, gain_changed
//  csr_        | in  | csr_valid/csr_ready  | wanted_rssi
//
// a new non-zero sample goes from transfer to result through 32 squaring steps
// of the shared multiplier for the two logs, then difference, scaling and decision
// a zero or repeated sample skips the calculation and goes straight to the result
// synchronous reset sets lna 11, pga 31, last sample 0, wanted_rssi 28672
// the next sample is taken while the previous result still waits under rsp_stall
// csr_ready is low while a sample is offered or in flight
`timescale 1ns / 1ps
`default_nettype none

module rx_agc_gain_stepper_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [rxagc_pkg::RSSI_W-1:0]      req_rssi_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [rxagc_pkg::LNA_W-1:0]       rsp_lna_gain,
   output logic      [rxagc_pkg::PGA_W-1:0]       rsp_pga_gain,
   output logic                                   rsp_gain_changed,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rxagc_pkg::RSSI_W-1:0]      csr_wanted_rssi
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_OUT
   } state_type;

   state_type state_ff;
   logic [rxagc_pkg::RSSI_W-1:0]  wanted_ff;
   logic [rxagc_pkg::LNA_W-1:0]   lna_ff;
   logic [rxagc_pkg::PGA_W-1:0]   pga_ff;
   logic [rxagc_pkg::RSSI_W-1:0]  prev_ff;
   logic [rxagc_pkg::RSSI_W-1:0]  rssi_ff;
   logic                          chg_ff;
   logic                          rsp_valid_ff;
   logic [rxagc_pkg::LNA_W-1:0]   rsp_lna_ff;
   logic [rxagc_pkg::PGA_W-1:0]   rsp_pga_ff;
   logic                          rsp_chg_ff;

   logic                          req_xfer;
   logic                          skip;
   logic                          calc_start;
   logic                          calc_done;
   logic [rxagc_pkg::RSSI_W-1:0]  wanted_eff;
   logic signed [rxagc_pkg::DB_W-1:0] db;
   rxagc_pkg::gain_upd_type       upd;
   logic                          out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE) && !req_valid;
   assign req_xfer   = req_valid && !req_stall;
   assign skip       = (req_rssi_sample == '0) || (req_rssi_sample == prev_ff);
   assign calc_start = req_xfer && !skip;
   assign wanted_eff = (wanted_ff == '0) ? rxagc_pkg::RSSI_W'(1) : wanted_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   rxagc_log_db u_log_db (
      .clock  (clock),
      .reset  (reset),
      .start  (calc_start),
      .wanted (wanted_eff),
      .sample (req_rssi_sample),
      .done   (calc_done),
      .db     (db)
   );

   rxagc_gain_sel u_gain_sel (
      .lna    (lna_ff),
      .pga    (pga_ff),
      .sample (rssi_ff),
      .db     (db),
      .upd    (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wanted_ff    <= rxagc_pkg::WANTED_RESET;
         lna_ff       <= rxagc_pkg::LNA_RESET;
         pga_ff       <= rxagc_pkg::PGA_RESET;
         prev_ff      <= '0;
         chg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            wanted_ff <= csr_wanted_rssi;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  rssi_ff <= req_rssi_sample;
                  chg_ff  <= 1'b0;
                  state_ff <= skip ? ST_OUT : ST_CALC;
               end
            end
            ST_CALC: begin
               if (calc_done) begin
                  lna_ff   <= upd.lna;
                  pga_ff   <= upd.pga;
                  chg_ff   <= upd.changed;
                  prev_ff  <= rssi_ff;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_lna_ff   <= lna_ff;
                  rsp_pga_ff   <= pga_ff;
                  rsp_chg_ff   <= chg_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lna_gain     = rsp_lna_ff;
   assign rsp_pga_gain     = rsp_pga_ff;
   assign rsp_gain_changed = rsp_chg_ff;

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      calc_done |-> state_ff == ST_CALC)
      else $error("level error finished outside calculation");

   a_calc_new_sample: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |-> rssi_ff != '0 && rssi_ff != prev_ff)
      else $error("calculation running on a zero or repeated sample");

   a_skip_no_change: assert property (@(posedge clock) disable iff (reset)
      req_xfer && skip |=> state_ff == ST_OUT && !chg_ff)
      else $error("skipped sample flagged a gain change");

endmodule

`default_nettype wire

// ===== tb/rx_agc_gain_stepper_checker.sv =====
// checker for the rx agc gain stepper: predicts each gain update and compares it on transfer
`timescale 1ns / 1ps

module rx_agc_gain_stepper_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [rxagc_pkg::RSSI_W-1:0] req_rssi_sample,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [rxagc_pkg::LNA_W-1:0]  rsp_lna_gain,
   input  logic [rxagc_pkg::PGA_W-1:0]  rsp_pga_gain,
   input  logic                         rsp_gain_changed,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [rxagc_pkg::RSSI_W-1:0] csr_wanted_rssi,
   output int                           error_count,
   output int                           waiting,
   output int                           checked,
   output int                           updates
);

   localparam int LNA_STEPS [0:61] = '{
      1, 1, 1, 2, 2, 2, 2, 3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 6, 6,
      6, 6, 7, 7, 7, 7, 8, 8, 8, 8, 9, 9, 9, 9, 10, 10, 10, 10,
      11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11,
      12, 13, 14, 15
   };

   localparam int PGA_STEPS [0:61] = '{
      0, 1, 2, 0, 1, 2, 3, 1, 2, 3, 4, 2, 3, 4, 5, 3, 4, 5, 6, 4, 5,
      6, 7, 5, 6, 7, 8, 6, 7, 8, 9, 7, 8, 9, 10, 10, 11, 12, 13,
      13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31,
      31, 31, 31, 31
   };

   logic [rxagc_pkg::RSSI_W-1:0] target_level;
   logic [rxagc_pkg::RSSI_W-1:0] last_level;
   logic [rxagc_pkg::LNA_W-1:0]  lna_now;
   logic [rxagc_pkg::PGA_W-1:0]  pga_now;
   rxagc_pkg::gain_upd_type      gains_q [$];

   initial begin
      error_count = 0;
      waiting     = 0;
      checked     = 0;
      updates     = 0;
   end

   // log2 in q5.16, fraction by repeated squaring of the normalized mantissa
   function automatic logic [20:0] level_log2(input logic [rxagc_pkg::RSSI_W-1:0] x);
      logic [rxagc_pkg::RSSI_W-1:0] t;
      logic [4:0]                   e;
      logic [63:0]                  m;
      logic [15:0]                  fr;
      t  = x;
      e  = '0;
      fr = '0;
      while (t > 1) begin
         t = t >> 1;
         e = e + 1'b1;
      end
      m = {46'd0, x} << (31 - e);
      repeat (16) begin
         m  = (m * m) >> 31;
         fr = fr << 1;
         if (m[32]) begin
            fr[0] = 1'b1;
            m     = m >> 1;
         end
      end
      return {e, fr};
   endfunction

   // level error in q8.8 dB, rounded toward minus infinity
   function automatic int level_error_db(input logic [rxagc_pkg::RSSI_W-1:0] w,
                                         input logic [rxagc_pkg::RSSI_W-1:0] r);
      longint lw;
      longint lr;
      longint p;
      lw = longint'(level_log2(w));
      lr = longint'(level_log2(r));
      p  = (lw - lr) * 64'sd394566;
      return int'(p >>> 24);
   endfunction

   function automatic rxagc_pkg::gain_upd_type next_gains(
      input logic [rxagc_pkg::RSSI_W-1:0] level);
      logic [rxagc_pkg::RSSI_W-1:0] w;
      int                           lna;
      int                           pga;
      int                           avail;
      int                           db;
      int                           sum;
      int                           idx;
      rxagc_pkg::gain_upd_type      res;
      res.changed = 1'b0;
      if (level != 0 && level != last_level) begin
         w     = (target_level == 0) ? 18'd1 : target_level;
         lna   = int'(lna_now);
         pga   = int'(pga_now);
         avail = (lna <= 9) ? 3 * (11 - lna) : 15 - lna;
         db    = level_error_db(w, level);
         last_level = level;
         if (db < 0 && level > 18'h14000) begin
            // coarse back-off for a strong signal
            pga_now     = (pga >= 12) ? rxagc_pkg::PGA_W'(pga - 12) : '0;
            lna_now     = (lna >= 3) ? rxagc_pkg::LNA_W'(lna - 3) : '0;
            res.changed = 1'b1;
         end else if (db < 0 || (db > 0 && avail + 31 - pga > 0)) begin
            sum = (30 - avail + pga) * 256 + db;
            idx = (sum >= 0) ? (sum >>> 8) : -((-sum) >>> 8);
            idx = (idx < 0) ? 0 : (idx > 61) ? 61 : idx;
            if (LNA_STEPS[idx] != lna || PGA_STEPS[idx] != pga) begin
               lna_now     = rxagc_pkg::LNA_W'(LNA_STEPS[idx]);
               pga_now     = rxagc_pkg::PGA_W'(PGA_STEPS[idx]);
               res.changed = 1'b1;
            end
         end
      end
      res.lna = lna_now;
      res.pga = pga_now;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rxagc_pkg::gain_upd_type want;
      if (reset) begin
         target_level = 18'd28672;
         last_level   = '0;
         lna_now      = 4'd11;
         pga_now      = 5'd31;
         gains_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            target_level = csr_wanted_rssi;
         end
         if (req_valid && !req_stall) begin
            gains_q.push_back(next_gains(req_rssi_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            checked = checked + 1;
            if (rsp_gain_changed) begin
               updates = updates + 1;
            end
            if (gains_q.size() == 0) begin
               error_count = error_count + 1;
               $display("%0t: unexpected transfer, expected none, %s %0d pga %0d changed %0d",
                        $time, "actual lna", rsp_lna_gain, rsp_pga_gain,
                        rsp_gain_changed);
            end else begin
               want = gains_q.pop_front();
               if (rsp_lna_gain !== want.lna) begin
                  error_count = error_count + 1;
                  $display("%0t: lna_gain expected %0d actual %0d",
                           $time, want.lna, rsp_lna_gain);
               end
               if (rsp_pga_gain !== want.pga) begin
                  error_count = error_count + 1;
                  $display("%0t: pga_gain expected %0d actual %0d",
                           $time, want.pga, rsp_pga_gain);
               end
               if (rsp_gain_changed !== want.changed) begin
                  error_count = error_count + 1;
                  $display("%0t: gain_changed expected %0d actual %0d",
                           $time, want.changed, rsp_gain_changed);
               end
            end
         end
      end
      waiting <= gains_q.size();
   end

endmodule

// ===== tb/rx_agc_gain_stepper_core_tb.sv =====
// testbench top for the rx agc gain stepper: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module rx_agc_gain_stepper_core_tb;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 70;
   localparam int TAIL_CYCLES  = 40;

   localparam logic [rxagc_pkg::RSSI_W-1:0] OPENING [0:22] = '{
      18'd0, 18'd28672, 18'd28672, 18'd20000, 18'h14000, 18'h14001, 18'h3FFFF,
      18'd200000, 18'd210000, 18'd220000, 18'd1, 18'd2, 18'd28672, 18'd3, 18'd100,
      18'd1000, 18'd30000, 18'd29000, 18'h13FFF, 18'h20000, 18'h2AAAA, 18'h15555, 18'd0
   };

   localparam logic [rxagc_pkg::RSSI_W-1:0] TARGETS [0:5] = '{
      18'd1, 18'h3FFFF, 18'd0, 18'd28672, 18'h14000, 18'd500
   };

   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         req_valid       = 1'b0;
   logic [rxagc_pkg::RSSI_W-1:0] req_rssi_sample = '0;
   logic                         rsp_stall       = 1'b0;
   logic                         csr_valid       = 1'b0;
   logic [rxagc_pkg::RSSI_W-1:0] csr_wanted_rssi = '0;

   logic                         req_stall;
   logic                         rsp_valid;
   logic [rxagc_pkg::LNA_W-1:0]  rsp_lna_gain;
   logic [rxagc_pkg::PGA_W-1:0]  rsp_pga_gain;
   logic                         rsp_gain_changed;
   logic                         csr_ready;

   int                           error_count;
   int                           waiting;
   int                           checked;
   int                           updates;
   int                           cycle_count = 0;
   int                           gap_pct     = 0;
   int                           stall_pct   = 0;
   logic [rxagc_pkg::RSSI_W-1:0] target      = 18'd28672;
   logic [rxagc_pkg::RSSI_W-1:0] last_sent   = '0;

   rx_agc_gain_stepper_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rssi_sample  (req_rssi_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lna_gain     (rsp_lna_gain),
      .rsp_pga_gain     (rsp_pga_gain),
      .rsp_gain_changed (rsp_gain_changed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wanted_rssi  (csr_wanted_rssi)
   );

   rx_agc_gain_stepper_checker chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rssi_sample  (req_rssi_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lna_gain     (rsp_lna_gain),
      .rsp_pga_gain     (rsp_pga_gain),
      .rsp_gain_changed (rsp_gain_changed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wanted_rssi  (csr_wanted_rssi),
      .error_count      (error_count),
      .waiting          (waiting),
      .checked          (checked),
      .updates          (updates)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rx_agc_gain_stepper_core_tb failed");
         $finish;
      end
   end

   // one sample transfer, with a random idle gap in front of it
   task automatic send_sample(input logic [rxagc_pkg::RSSI_W-1:0] level);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
      req_valid       <= 1'b1;
      req_rssi_sample <= level;
      last_sent = level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   task automatic write_target(input logic [rxagc_pkg::RSSI_W-1:0] level);
      csr_valid       <= 1'b1;
      csr_wanted_rssi <= level;
      target = level;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // about half of the levels at or near the target so the loop walks the gain table
   function automatic logic [rxagc_pkg::RSSI_W-1:0] pick_level();
      int unsigned                  roll;
      int unsigned                  shift;
      logic [rxagc_pkg::RSSI_W-1:0] base;
      logic [24:0]                  wide;
      roll = $urandom_range(0, 99);
      base = (target == 0) ? 18'd1 : target;
      if (roll < 6) begin
         return '0;
      end
      if (roll < 14) begin
         return last_sent;
      end
      if (roll < 22) begin
         return base;
      end
      if (roll < 62) begin
         shift = $urandom_range(0, 6);
         wide  = (shift >= 3) ? ({7'd0, base} << (shift - 3)) : ({7'd0, base} >> (3 - shift));
         wide  = wide ^ 25'($urandom_range(0, 255));
         return (wide > 25'h3FFFF) ? 18'h3FFFF : wide[rxagc_pkg::RSSI_W-1:0];
      end
      shift = $urandom_range(1, rxagc_pkg::RSSI_W);
      return rxagc_pkg::RSSI_W'($urandom_range(0, (1 << shift) - 1));
   endfunction

   initial begin : stimulus
      int phase;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      foreach (OPENING[i]) begin
         send_sample(OPENING[i]);
      end
      settle();
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin
               gap_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               gap_pct = 54;
               stall_pct <= 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct <= 54;
            end
            default: begin
               gap_pct = 21;
               stall_pct <= 21;
            end
         endcase
         write_target((phase < 6) ? TARGETS[phase]
                                  : rxagc_pkg::RSSI_W'($urandom_range(1, 262143)));
         repeat (PHASE_ITEMS) send_sample(pick_level());
         settle();
      end
      stall_pct <= 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d rssi samples, %0d of them with a gain update", checked, updates);
      $display("targets: reset value and %0d written, including 0, 1 and full scale", PHASES);
      if (error_count == 0) begin
         $display("rx_agc_gain_stepper_core_tb passed");
      end else begin
         $display("rx_agc_gain_stepper_core_tb failed");
      end
      $finish;
   end

endmodule
